/* src/brfw_pkg.sv */
// brfw_pkg.sv: shared types, widths, register map and helpers of the bilinear resize unit
// no dependencies; imported by the sequencer, the multiply-accumulate unit and the bench
`default_nettype none

package brfw_pkg;

  // payload field widths
  localparam int POS_W      = 10;
  localparam int PIX_W      = 16;
  localparam int ISZ_W      = 9;
  localparam int OSZ_W      = 11;
  localparam int IN_TDATA_W = 40;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_16BIT = 3'd4;

  localparam logic [ISZ_W-1:0] RST_IN_SIZE  = 9'd256;
  localparam logic [OSZ_W-1:0] RST_OUT_SIZE = 11'd256;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  // parameter defaults
  localparam int DEF_MAX_IN_HEIGHT  = 256;
  localparam int DEF_MAX_IN_WIDTH   = 256;
  localparam int DEF_MAX_OUT_HEIGHT = 1024;
  localparam int DEF_MAX_OUT_WIDTH  = 1024;
  localparam int DEF_WEIGHT_BITS    = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVS,
    ST_DIV,
    ST_FIN,
    ST_TAP,
    ST_MAC,
    ST_BLEND,
    ST_DONE
  } brfw_state_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [OSZ_W-1:0] clamp_size(input logic [OSZ_W-1:0] v,
                                                  input int unsigned mx);
    logic [OSZ_W-1:0] res;
    if (v == '0) begin
      res = OSZ_W'(1);
    end else if (32'(v) > mx) begin
      res = OSZ_W'(mx);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/bilinear_resize_fixed_weights_unit.sv */
// bilinear_resize_fixed_weights_unit.sv: top level, sequencer, config registers and datapath glue
// depends on brfw_pkg, brfw_div, brfw_store and brfw_mac
//
// usage
//   in channel: a beat with in_tuser = 0 writes one source sample into the frame store at
//   (row, col); out-of-range loads are dropped. a beat with in_tuser = 1 asks for the output
//   sample at (row, col) and produces exactly one out beat; loads produce none.
//   out channel: out_tdata carries the blended sample, out_tuser flags a coordinate outside
//   the output grid (sample then reads 0).
//   cfg port: APB-style, registers at byte addresses 0, 4, 8, 12, 16; writes only while idle.
// sequence
//   for a compute, the shared divider resolves the row and then the column coordinate at one
//   quotient bit per cycle (skipped for an axis that maps to zero), then four store reads feed
//   the shared multiply-accumulate unit and two more steps blend the rows. a coordinate error
//   skips the mapping and goes from acceptance straight to the done state. in_tready is high
//   only while idle.
// reset and stall
//   rst_n (synchronous) returns the sizes to 256x256 -> 256x256 in 16-bit mode and empties
//   the out register; the frame store is not cleared. a finished result sits in the out
//   register, so the next beat is accepted while out_tready is low; a second result waits
//   in the sequencer until the register drains.
`default_nettype none

module bilinear_resize_fixed_weights_unit
  import brfw_pkg::*;
#(
  parameter int MAX_IN_HEIGHT  = DEF_MAX_IN_HEIGHT,
  parameter int MAX_IN_WIDTH   = DEF_MAX_IN_WIDTH,
  parameter int MAX_OUT_HEIGHT = DEF_MAX_OUT_HEIGHT,
  parameter int MAX_OUT_WIDTH  = DEF_MAX_OUT_WIDTH,
  parameter int WEIGHT_BITS    = DEF_WEIGHT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // row [9:0], col [19:10], pixel [35:20], zero [39:36]
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // kind [0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_pixel [15:0]
  output logic [PIX_W-1:0]           out_tdata,
  // coord_error [0]
  output logic                       out_tuser
);

  localparam int WB    = WEIGHT_BITS;
  localparam int WW    = WB + 1;
  localparam int QW    = ISZ_W + WB;
  localparam int A_W   = ISZ_W + POS_W + 1;
  localparam int NW    = A_W + WB;
  localparam int DVW   = OSZ_W + 1;
  localparam int V_W   = PIX_W + WB;
  localparam int P_W   = PIX_W + 2 * WB;
  localparam int DEPTH = MAX_IN_HEIGHT * MAX_IN_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [WW-1:0] SCALE = WW'(2 ** WB);

  // configuration registers
  logic [ISZ_W-1:0] ih_r, iw_r;
  logic [OSZ_W-1:0] oh_r, ow_r;
  logic             s16_r;
  logic [ISZ_W-1:0] ih_eff, iw_eff;
  logic [OSZ_W-1:0] oh_eff, ow_eff;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  assign ih_eff = ISZ_W'(clamp_size(OSZ_W'(ih_r), MAX_IN_HEIGHT));
  assign iw_eff = ISZ_W'(clamp_size(OSZ_W'(iw_r), MAX_IN_WIDTH));
  assign oh_eff = clamp_size(oh_r, MAX_OUT_HEIGHT);
  assign ow_eff = clamp_size(ow_r, MAX_OUT_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ih_r  <= RST_IN_SIZE;
      iw_r  <= RST_IN_SIZE;
      oh_r  <= RST_OUT_SIZE;
      ow_r  <= RST_OUT_SIZE;
      s16_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IN_HEIGHT:    ih_r  <= cfg_pwdata[ISZ_W-1:0];
        REG_IN_WIDTH:     iw_r  <= cfg_pwdata[ISZ_W-1:0];
        REG_OUT_HEIGHT:   oh_r  <= cfg_pwdata[OSZ_W-1:0];
        REG_OUT_WIDTH:    ow_r  <= cfg_pwdata[OSZ_W-1:0];
        REG_SAMPLE_16BIT: s16_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IN_HEIGHT:    cfg_prdata = CFG_DATA_W'(ih_r);
      REG_IN_WIDTH:     cfg_prdata = CFG_DATA_W'(iw_r);
      REG_OUT_HEIGHT:   cfg_prdata = CFG_DATA_W'(oh_r);
      REG_OUT_WIDTH:    cfg_prdata = CFG_DATA_W'(ow_r);
      REG_SAMPLE_16BIT: cfg_prdata = CFG_DATA_W'(s16_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // input beat fields
  logic [POS_W-1:0] in_row, in_col;
  logic [PIX_W-1:0] in_pix;
  logic             in_acc;

  assign in_row = in_tdata[POS_W-1:0];
  assign in_col = in_tdata[2*POS_W-1:POS_W];
  assign in_pix = in_tdata[2*POS_W+PIX_W-1:2*POS_W];
  assign in_acc = in_tvalid & in_tready;

  // sequencer state
  brfw_state_t       state_r, state_nxt;
  logic              axis_r, axis_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [A_W-1:0]    a_r, a_nxt;
  logic              qz_r, qz_nxt;
  logic [ISZ_W-1:0]  r0_r, r0_nxt, c0_r, c0_nxt;
  logic [WB-1:0]     fu_r, fu_nxt, fv_r, fv_nxt;
  logic [V_W-1:0]    v0_r, v0_nxt;
  logic [PIX_W-1:0]  out_pix_r, out_pix_nxt;
  logic              out_err_r, out_err_nxt;

  // coordinate mapping datapath
  logic [POS_W-1:0]  pos_sel;
  logic [ISZ_W-1:0]  isz_sel;
  logic [OSZ_W-1:0]  osz_sel;
  logic [A_W-1:0]    a_prod;
  logic              a_gt;
  logic [NW-1:0]     div_dividend;
  logic [DVW-1:0]    div_divisor;
  logic              div_start;
  logic              div_done;
  logic [QW-1:0]     div_q;
  logic [QW-1:0]     q_raw, q_lim, q_cl;

  assign pos_sel      = axis_r ? col_r : row_r;
  assign isz_sel      = axis_r ? iw_eff : ih_eff;
  assign osz_sel      = axis_r ? ow_eff : oh_eff;
  assign a_prod       = A_W'({pos_sel, 1'b1}) * A_W'(isz_sel);
  assign a_gt         = a_r > A_W'(osz_sel);
  assign div_dividend = {a_r - A_W'(osz_sel), {WB{1'b0}}};
  assign div_divisor  = {osz_sel, 1'b0};
  assign div_start    = (state_r == ST_DIVS) && a_gt;
  assign q_raw        = qz_r ? '0 : div_q;
  assign q_lim        = {isz_sel - ISZ_W'(1), {WB{1'b0}}};
  assign q_cl         = (q_raw > q_lim) ? q_lim : q_raw;

  brfw_div #(
    .NW(NW),
    .DW(DVW),
    .QW(QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_q)
  );

  // frame store access
  logic [ISZ_W-1:0]  r1, c1, rd_row, rd_col;
  logic [1:0]        rd_k;
  logic [AW-1:0]     rd_addr, wr_addr, st_addr;
  logic              st_we;
  logic              ld_ok;
  logic [PIX_W-1:0]  st_rdata, tap16;

  assign r1      = (fu_r != '0) ? r0_r + ISZ_W'(1) : r0_r;
  assign c1      = (fv_r != '0) ? c0_r + ISZ_W'(1) : c0_r;
  assign rd_k    = (state_r == ST_MAC) ? k_r + 2'd1 : 2'd0;
  assign rd_row  = rd_k[1] ? r1 : r0_r;
  assign rd_col  = rd_k[0] ? c1 : c0_r;
  assign rd_addr = AW'(rd_row) * AW'(MAX_IN_WIDTH) + AW'(rd_col);
  assign wr_addr = AW'(in_row) * AW'(MAX_IN_WIDTH) + AW'(in_col);
  assign ld_ok   = (in_row < POS_W'(ih_eff)) && (in_col < POS_W'(iw_eff));
  assign st_we   = in_acc && (in_tuser == KIND_LOAD) && ld_ok;
  assign st_addr = st_we ? wr_addr : rd_addr;
  assign tap16   = s16_r ? st_rdata : {8'h00, st_rdata[7:0]};

  brfw_store #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (PIX_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (in_pix),
    .rdata (st_rdata)
  );

  // shared multiply-accumulate
  mac_ctl_t        mac_ctl;
  logic [V_W-1:0]  mac_a;
  logic [WW-1:0]   mac_b;
  logic [P_W-1:0]  acc;

  always_comb begin
    mac_ctl = '0;
    mac_a   = V_W'(tap16);
    mac_b   = '0;
    case (state_r)
      ST_MAC: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = !k_r[0];
        mac_a       = V_W'(tap16);
        mac_b       = k_r[0] ? WW'(fv_r) : SCALE - WW'(fv_r);
      end
      ST_BLEND: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = !k_r[0];
        mac_a       = k_r[0] ? v0_r : acc[V_W-1:0];
        mac_b       = k_r[0] ? SCALE - WW'(fu_r) : WW'(fu_r);
      end
      default: ;
    endcase
  end

  brfw_mac #(
    .A_W  (V_W),
    .B_W  (WW),
    .ACC_W(P_W)
  ) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    k_nxt         = k_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    a_nxt         = a_r;
    qz_nxt        = qz_r;
    r0_nxt        = r0_r;
    c0_nxt        = c0_r;
    fu_nxt        = fu_r;
    fv_nxt        = fv_r;
    v0_nxt        = v0_r;
    out_pix_nxt   = out_pix_r;
    out_err_nxt   = out_err_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == KIND_COMPUTE)) begin
          row_nxt  = in_row;
          col_nxt  = in_col;
          axis_nxt = 1'b0;
          if ((OSZ_W'(in_row) >= oh_eff) || (OSZ_W'(in_col) >= ow_eff)) begin
            err_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        a_nxt     = a_prod;
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        qz_nxt    = !a_gt;
        state_nxt = a_gt ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!axis_r) begin
          r0_nxt    = q_cl[QW-1:WB];
          fu_nxt    = q_cl[WB-1:0];
          axis_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          c0_nxt    = q_cl[QW-1:WB];
          fv_nxt    = q_cl[WB-1:0];
          k_nxt     = 2'd0;
          state_nxt = ST_TAP;
        end
      end
      ST_TAP: begin
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        // top row total is in the accumulator when the first bottom tap arrives
        if (k_r == 2'd2) begin
          v0_nxt = acc[V_W-1:0];
        end
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = err_r ? '0 : acc[P_W-1:2*WB];
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      k_r         <= 2'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      k_r         <= k_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    a_r       <= a_nxt;
    qz_r      <= qz_nxt;
    r0_r      <= r0_nxt;
    c0_r      <= c0_nxt;
    fu_r      <= fu_nxt;
    fv_r      <= fv_nxt;
    v0_r      <= v0_nxt;
    out_pix_r <= out_pix_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_err_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside divide wait");

  // a flagged coordinate never carries a sample
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("coordinate error beat with nonzero sample");

  // 8-bit mode keeps results within a byte
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !s16_r) |-> (out_tdata[PIX_W-1:8] == '0))
    else $error("8-bit mode result above 255");

  // a nonzero row fraction leaves room for the next row tap
  a_row_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAP) |-> ((fu_r == '0) || (r0_r < ih_eff - ISZ_W'(1))))
    else $error("second row tap beyond source height");

endmodule

`default_nettype wire

/* src/brfw_div.sv */
// brfw_div.sv: restoring divider, one quotient bit per cycle
// standalone; the quotient is known to fit QW bits, so the upper dividend bits preload the remainder
`default_nettype none

module brfw_div #(
  parameter int NW = 28,
  parameter int DW = 12,
  parameter int QW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [QW-1:0]      quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = DW'(dividend[NW-1:QW]);
      quo_nxt  = dividend[QW-1:0];
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

/* src/brfw_store.sv */
// brfw_store.sv: single-port frame store with registered read data
// standalone; one write or one read per cycle
`default_nettype none

module brfw_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/brfw_mac.sv */
// brfw_mac.sv: shared multiply-accumulate unit for tap weighting and row blending
// depends on brfw_pkg for the control struct
`default_nettype none

module brfw_mac
  import brfw_pkg::*;
#(
  parameter int A_W   = 24,
  parameter int B_W   = 9,
  parameter int ACC_W = 32
) (
  input  wire logic             clk,
  input  wire mac_ctl_t         ctl,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic [ACC_W-1:0]      acc
);

  logic [A_W+B_W-1:0] prod;
  logic [ACC_W-1:0]   acc_r, acc_nxt;

  assign prod = a * b;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      acc_nxt = (ctl.clr ? '0 : acc_r) + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* tb/bilinear_resize_fixed_weights_unit_test.sv */
`timescale 1ns / 100ps
// bilinear_resize_fixed_weights_unit_test.sv: self-checking bench for the bilinear resize unit
// streams loads and computes, sets sizes over apb, predicts and checks every out beat
// depends on brfw_pkg and bilinear_resize_fixed_weights_unit
module bilinear_resize_fixed_weights_unit_test
  import brfw_pkg::*;
;

  localparam int CLK_PERIOD      = 20;
  localparam int ROW_STRIDE      = 256;
  localparam int FRAC_BITS       = 8;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int DRAIN_CYCLES    = 200;
  localparam int PRESSURE_AT     = 150;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } pixel_op_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_val;
    logic             coord_error;
  } resize_result_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // row [9:0], col [19:10], pixel [35:20], zero [39:36]
  logic [IN_TDATA_W-1:0] in_tdata    = '0;
  // kind [0]
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // out_pixel [15:0]
  logic [PIX_W-1:0]      out_tdata;
  // coord_error [0]
  logic                  out_tuser;

  bilinear_resize_fixed_weights_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state
  int unsigned    eff_in_h  = 256;
  int unsigned    eff_in_w  = 256;
  int unsigned    eff_out_h = 256;
  int unsigned    eff_out_w = 256;
  bit             mode_16   = 1'b1;
  logic [PIX_W-1:0] store_model [0:65535];
  resize_result_t expected_pixels [$];

  // stimulus side
  pixel_op_t pending_ops [$];
  bit        written_map [0:65535];
  pixel_op_t cur_op;
  int        queued_count  = 0;
  int        work_items    = 0;
  int        in_beats      = 0;
  int        gap_left      = 0;
  int        stall_left    = 0;
  int        hold_left     = 0;
  bit        pressure_done = 1'b0;
  bit        quiet         = 1'b0;
  bit        ready_next;

  int             mismatches    = 0;
  int             checked_beats = 0;
  int             load_beats    = 0;
  int             compute_beats = 0;
  int             offgrid_beats = 0;
  int             size_settings = 0;
  int             cycle_count   = 0;
  resize_result_t want;

  function automatic int unsigned size_limit(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic void map_src(input int unsigned pos, input int unsigned isz,
                                  input int unsigned osz, output int unsigned idx,
                                  output int unsigned frac);
    longint unsigned a, q, lim;
    a   = (2 * longint'(pos) + 1) * longint'(isz);
    q   = 0;
    lim = (longint'(isz) - 1) << FRAC_BITS;
    if (a > osz) q = ((a - osz) << FRAC_BITS) / (2 * longint'(osz));
    if (q > lim) q = lim;
    idx  = int'(q >> FRAC_BITS);
    frac = int'(q & ((1 << FRAC_BITS) - 1));
  endfunction

  function automatic longint unsigned tap_at(int unsigned r, int unsigned c);
    longint unsigned v;
    v = store_model[r * ROW_STRIDE + c];
    return mode_16 ? v : (v & 'hFF);
  endfunction

  function automatic resize_result_t blend_at(int unsigned row, int unsigned col);
    resize_result_t  res;
    int unsigned     r0, fu, c0, fv, r1, c1;
    longint unsigned v0, v1, sum, one;
    one = 1 << FRAC_BITS;
    res = '0;
    if (row >= eff_out_h || col >= eff_out_w) begin
      res.coord_error = 1'b1;
      return res;
    end
    map_src(row, eff_in_h, eff_out_h, r0, fu);
    map_src(col, eff_in_w, eff_out_w, c0, fv);
    r1  = (fu != 0) ? r0 + 1 : r0;
    c1  = (fv != 0) ? c0 + 1 : c0;
    v0  = tap_at(r0, c0) * (one - fv) + tap_at(r0, c1) * fv;
    v1  = tap_at(r1, c0) * (one - fv) + tap_at(r1, c1) * fv;
    sum = (v0 * (one - fu) + v1 * fu) >> (2 * FRAC_BITS);
    res.pix_val = sum[PIX_W-1:0];
    return res;
  endfunction

  task automatic absorb_op(pixel_op_t op);
    if (op.kind == KIND_LOAD) begin
      load_beats++;
      if (op.row < eff_in_h && op.col < eff_in_w)
        store_model[op.row * ROW_STRIDE + op.col] = op.pixel;
    end else begin
      compute_beats++;
      if (op.row >= eff_out_h || op.col >= eff_out_w) offgrid_beats++;
      expected_pixels.push_back(blend_at(op.row, op.col));
    end
  endtask

  task automatic queue_load(int unsigned row, int unsigned col, int unsigned pix);
    pixel_op_t op;
    op.kind  = KIND_LOAD;
    op.row   = row[POS_W-1:0];
    op.col   = col[POS_W-1:0];
    op.pixel = pix[PIX_W-1:0];
    pending_ops.push_back(op);
    queued_count++;
    work_items++;
    if (row < eff_in_h && col < eff_in_w) begin
      written_map[row * ROW_STRIDE + col] = 1'b1;
    end
  endtask

  task automatic ensure_tap(int unsigned r, int unsigned c);
    if (!written_map[r * ROW_STRIDE + c]) queue_load(r, c, $urandom_range(0, 65535));
  endtask

  // every tap a compute will read gets loaded first
  task automatic queue_compute(int unsigned row, int unsigned col);
    pixel_op_t   op;
    int unsigned r0, fu, c0, fv, r1, c1;
    if (row < eff_out_h && col < eff_out_w) begin
      map_src(row, eff_in_h, eff_out_h, r0, fu);
      map_src(col, eff_in_w, eff_out_w, c0, fv);
      r1 = (fu != 0) ? r0 + 1 : r0;
      c1 = (fv != 0) ? c0 + 1 : c0;
      ensure_tap(r0, c0);
      ensure_tap(r0, c1);
      ensure_tap(r1, c0);
      ensure_tap(r1, c1);
    end
    op.kind  = KIND_COMPUTE;
    op.row   = row[POS_W-1:0];
    op.col   = col[POS_W-1:0];
    op.pixel = PIX_W'($urandom_range(0, 65535));
    pending_ops.push_back(op);
    queued_count++;
    work_items++;
  endtask

  task automatic wait_idle();
    while (in_beats != queued_count || expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_IN_HEIGHT:    eff_in_h  = size_limit(value & 'h1FF, DEF_MAX_IN_HEIGHT);
      REG_IN_WIDTH:     eff_in_w  = size_limit(value & 'h1FF, DEF_MAX_IN_WIDTH);
      REG_OUT_HEIGHT:   eff_out_h = size_limit(value & 'h7FF, DEF_MAX_OUT_HEIGHT);
      REG_OUT_WIDTH:    eff_out_w = size_limit(value & 'h7FF, DEF_MAX_OUT_WIDTH);
      REG_SAMPLE_16BIT: mode_16   = value[0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(int unsigned ih, int unsigned iw, int unsigned oh,
                           int unsigned ow, int unsigned s16);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_OUT_HEIGHT, oh);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_SAMPLE_16BIT, s16);
    size_settings++;
  endtask

  task automatic run_random(int unsigned ih, int unsigned iw, int unsigned oh,
                            int unsigned ow, int unsigned s16, int n);
    int          goal;
    int unsigned sel;
    set_sizes(ih, iw, oh, ow, s16);
    goal = work_items + n;
    while (work_items < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 55)
        queue_compute($urandom_range(0, eff_out_h - 1), $urandom_range(0, eff_out_w - 1));
      else if (sel < 63)
        queue_compute($urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (sel < 90)
        queue_load($urandom_range(0, eff_in_h - 1), $urandom_range(0, eff_in_w - 1),
                   $urandom_range(0, 65535));
      else
        queue_load($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 65535));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // in stream driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        absorb_op(cur_op);
        in_beats++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, cur_op.pixel, cur_op.col, cur_op.row};
          in_tuser  <= cur_op.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // out stream ready, with one long hold so the input backs up
  always @(posedge clk) begin
    if (rst_n) begin
      if (!pressure_done && in_beats >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // out beat checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected out beat, actual pixel %h error %b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = expected_pixels.pop_front();
        checked_beats++;
        if (out_tdata !== want.pix_val) begin
          mismatches++;
          $display("%0t: out_pixel expected %h actual %h", $time, want.pix_val, out_tdata);
        end
        if (out_tuser !== want.coord_error) begin
          mismatches++;
          $display("%0t: coord_error expected %b actual %b",
                   $time, want.coord_error, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: corners, exact copy, dropped loads, off-grid computes
    queue_load(0, 0, 16'hFFFF);
    queue_load(255, 255, 16'h0000);
    queue_load(0, 255, 16'hAAAA);
    queue_load(255, 0, 16'h5555);
    queue_load(256, 10, 16'h1234);
    queue_load(1023, 1023, 16'hFFFF);
    queue_compute(0, 0);
    queue_compute(255, 255);
    queue_compute(0, 255);
    queue_compute(255, 0);
    queue_compute(256, 0);
    queue_compute(0, 1023);
    queue_compute(1023, 1023);
    queue_load(0, 0, 16'h0000);
    queue_compute(0, 0);

    // upscale with fractions and edge clamps
    set_sizes(4, 4, 9, 9, 1);
    queue_compute(0, 0);
    queue_compute(8, 8);
    queue_compute(4, 3);
    queue_compute(9, 3);

    // zero sizes act as one
    set_sizes(0, 0, 0, 0, 0);
    queue_compute(0, 0);
    queue_compute(1, 0);

    // oversized registers saturate, 8-bit samples
    set_sizes(511, 511, 2047, 2047, 0);
    queue_compute(1023, 1023);
    queue_compute(0, 0);
    queue_compute(511, 600);

    run_random(16, 16, 40, 24, 1, 120);
    run_random(8, 6, 3, 2, 0, 110);
    run_random(1, 256, 7, 1024, 1, 100);
    run_random(256, 1, 1024, 3, 0, 100);
    run_random(5, 7, 5, 7, 1, 100);
    run_random(256, 256, 256, 1024, 1, 100);
    repeat (3)
      run_random($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 80),
                 $urandom_range(0, 80), $urandom_range(0, 1), 100);
    quiet = 1'b1;
    run_random(12, 20, 33, 17, 0, 110);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
    end
    $display("ran %0d loads and %0d computes (%0d off grid) over %0d size settings",
             load_beats, compute_beats, offgrid_beats, size_settings);
    $display("checked %0d out beats, with random stalls and one %0d cycle output hold",
             checked_beats, PRESSURE_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
